/* src/rscm_pkg.sv */
`timescale 1ns / 1ps
// Package for the response slot claim manager: sizes, message constants,
// register indexes and the sequencer state type. Depends on nothing.
package rscm_pkg;

    localparam int SLOTS     = 32;
    localparam int SLOT_W    = 5;
    localparam int ACK_DEPTH = 32;
    localparam int FILL_W    = 6;

    localparam logic [7:0]        CLAIM_ID       = 8'hC1;
    localparam logic [7:0]        CLAIM_MIN_LEN  = 8'd5;
    localparam logic [FILL_W-1:0] ACK_CAP        = 6'd32;
    localparam logic [7:0]        MISS_MAX       = 8'd255;
    localparam logic [7:0]        RECLAIM_RESET  = 8'd20;
    localparam logic [5:0]        ACK_LIMIT_RESET = 6'd32;

    localparam logic REG_RECLAIM   = 1'b0;
    localparam logic REG_ACK_LIMIT = 1'b1;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 112;

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_CLAIM_SCAN = 8'b0000_0010,
        S_REQ_SCAN   = 8'b0000_0100,
        S_HDR        = 8'b0000_1000,
        S_RD         = 8'b0001_0000,
        S_LD         = 8'b0010_0000,
        S_OUT        = 8'b0100_0000,
        S_SPARE      = 8'b1000_0000
    } state_t;

endpackage

/* src/response_slot_claim_manager_top.sv */
`timescale 1ns / 1ps
// Response slot claim manager: slot ownership, miss ageing and ack framing.
// Depends on rscm_pkg.
//
// A response word is handled in the idle state, or for a claim by a scan of up to 32 slots
// (one slot compared per cycle by the shared token comparator). A request word scans every
// slot, then, if frames_wanted is nonzero, emits the header and each ack word through the
// read, load and output states, as the ack queue is read one entry at a time.
// Reset (aresetn, synchronous) frees every slot, clears the counters and the
// ack queue fill, and loads the register defaults; queue entries stay as is.
module response_slot_claim_manager_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // slot[7:0], msg_len[15:8], first_byte[23:16], claim_token[55:24],
    // frames_wanted[63:56]
    input  logic [rscm_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // open_map[31:0], retx_map[63:32], ack_total[69:64],
    // ack_token[101:70], ack_slot[106:102], zero pad above
    output logic [rscm_pkg::OUT_DATA_W-1:0]    m_tdata,
    // is_ack[0]
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [7:0]                         cfg_data
);
    import rscm_pkg::*;

    state_t state_reg, state_next;

    logic [7:0] reclaim_reg;
    logic [5:0] ack_limit_reg;

    logic [SLOTS-1:0] owned_reg;
    logic [SLOTS-1:0] responded_reg;
    logic [31:0]      token_reg [SLOTS];
    logic [7:0]       miss_reg  [SLOTS];
    logic [SLOTS-1:0] rt_reg;

    logic [31:0]       q_tok_mem  [ACK_DEPTH];
    logic [SLOT_W-1:0] q_slot_mem [ACK_DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [31:0]       rd_tok_reg;
    logic [SLOT_W-1:0] rd_slot_reg;

    logic [SLOT_W-1:0] idx_reg;
    logic [FILL_W-1:0] emit_idx_reg;
    logic [FILL_W-1:0] n_reg;

    // Latched word fields
    logic [SLOT_W-1:0] slot_reg;
    logic [31:0]       tok_reg;
    logic [7:0]        frames_reg;

    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;
    logic                  out_last_reg;
    logic                  out_valid_reg;

    logic              in_acc, out_acc;
    logic [7:0]        in_slot, in_len, in_fb, in_frames;
    logic [31:0]       in_tok;
    logic              slot_ok, is_claim;
    logic              hit;
    logic [7:0]        miss_inc;
    logic              rt_bit;
    logic [FILL_W-1:0] cap;
    logic              push_now;
    logic [31:0]       push_tok;
    logic [SLOT_W-1:0] push_slot;

    assign in_acc    = s_tvalid & s_tready;
    assign out_acc   = out_valid_reg & m_tready;
    assign in_slot   = s_tdata[7:0];
    assign in_len    = s_tdata[15:8];
    assign in_fb     = s_tdata[23:16];
    assign in_tok    = s_tdata[55:24];
    assign in_frames = s_tdata[63:56];
    assign slot_ok   = in_slot < 8'(SLOTS);
    assign is_claim  = (in_len >= CLAIM_MIN_LEN) && (in_fb == CLAIM_ID) && (in_tok != 32'd0);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Shared comparator and miss incrementer, both indexed by the scan counter
    assign hit      = owned_reg[idx_reg] && (token_reg[idx_reg] == tok_reg);
    assign miss_inc = (miss_reg[idx_reg] == MISS_MAX) ? MISS_MAX : miss_reg[idx_reg] + 8'd1;
    assign rt_bit   = owned_reg[idx_reg] && !responded_reg[idx_reg];
    assign cap      = (ack_limit_reg > ACK_CAP) ? ACK_CAP : ack_limit_reg;

    // Ack queue push from the claim scan
    always_comb begin
        push_now  = 1'b0;
        push_tok  = tok_reg;
        push_slot = slot_reg;
        if (state_reg == S_CLAIM_SCAN) begin
            if (hit) begin
                push_now = (idx_reg == slot_reg);
            end else if (idx_reg == SLOT_W'(SLOTS - 1)) begin
                push_now = !owned_reg[slot_reg];
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        state_next = S_REQ_SCAN;
                    end else if (slot_ok && is_claim) begin
                        state_next = S_CLAIM_SCAN;
                    end
                end
            end
            S_CLAIM_SCAN: begin
                if (hit || idx_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_REQ_SCAN: begin
                if (idx_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = (frames_reg != 8'd0) ? S_HDR : S_IDLE;
                end
            end
            S_HDR:  state_next = S_OUT;
            S_RD:   state_next = S_LD;
            S_LD:   state_next = S_OUT;
            S_OUT: begin
                if (out_acc) begin
                    if (out_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            reclaim_reg   <= RECLAIM_RESET;
            ack_limit_reg <= ACK_LIMIT_RESET;
            owned_reg     <= '0;
            responded_reg <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            emit_idx_reg  <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                token_reg[i] <= 32'd0;
                miss_reg[i]  <= 8'd0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    REG_RECLAIM:   reclaim_reg   <= cfg_data;
                    REG_ACK_LIMIT: ack_limit_reg <= cfg_data[5:0];
                    default:       ;
                endcase
            end

            if (push_now && fill_reg < FILL_W'(ACK_DEPTH)) begin
                fill_reg <= fill_reg + 6'd1;
            end

            case (state_reg)
                S_IDLE: begin
                    idx_reg <= '0;
                    if (in_acc && !s_tuser && slot_ok && !is_claim) begin
                        responded_reg[in_slot[SLOT_W-1:0]] <= 1'b1;
                    end
                end
                S_CLAIM_SCAN: begin
                    idx_reg <= idx_reg + 5'd1;
                    if (hit) begin
                        responded_reg[slot_reg] <= 1'b1;
                    end else if (idx_reg == SLOT_W'(SLOTS - 1)) begin
                        responded_reg[slot_reg] <= 1'b1;
                        if (!owned_reg[slot_reg]) begin
                            owned_reg[slot_reg] <= 1'b1;
                            token_reg[slot_reg] <= tok_reg;
                        end
                    end
                end
                S_REQ_SCAN: begin
                    idx_reg <= idx_reg + 5'd1;
                    responded_reg[idx_reg] <= 1'b0;
                    if (rt_bit) begin
                        if (miss_inc >= reclaim_reg) begin
                            owned_reg[idx_reg] <= 1'b0;
                            token_reg[idx_reg] <= 32'd0;
                            miss_reg[idx_reg]  <= 8'd0;
                        end else begin
                            miss_reg[idx_reg] <= miss_inc;
                        end
                    end else if (responded_reg[idx_reg]) begin
                        miss_reg[idx_reg] <= 8'd0;
                    end
                    if (idx_reg == SLOT_W'(SLOTS - 1) && frames_reg == 8'd0) begin
                        fill_reg <= '0;
                    end
                end
                S_HDR: begin
                    out_valid_reg <= 1'b1;
                    emit_idx_reg  <= '0;
                end
                S_LD: begin
                    out_valid_reg <= 1'b1;
                end
                S_OUT: begin
                    if (out_acc) begin
                        out_valid_reg <= 1'b0;
                        if (out_user_reg) begin
                            emit_idx_reg <= emit_idx_reg + 6'd1;
                        end
                        if (out_last_reg) begin
                            fill_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            slot_reg   <= in_slot[SLOT_W-1:0];
            tok_reg    <= in_tok;
            frames_reg <= in_frames;
        end
        if (state_reg == S_REQ_SCAN) begin
            rt_reg[idx_reg] <= rt_bit;
        end
        if (state_reg == S_REQ_SCAN && idx_reg == SLOT_W'(SLOTS - 1)) begin
            n_reg <= (fill_reg < cap) ? fill_reg : cap;
        end
        if (state_reg == S_HDR) begin
            out_data_reg <= {{(OUT_DATA_W - 70){1'b0}}, n_reg, rt_reg, ~owned_reg};
            out_user_reg <= 1'b0;
            out_last_reg <= (n_reg == 6'd0);
        end
        if (state_reg == S_LD) begin
            out_data_reg <= {{(OUT_DATA_W - 107){1'b0}}, rd_slot_reg, rd_tok_reg, 70'd0};
            out_user_reg <= 1'b1;
            out_last_reg <= (emit_idx_reg + 6'd1 == n_reg);
        end
    end

    // Ack queue memory
    always_ff @(posedge aclk) begin
        if (push_now && fill_reg < FILL_W'(ACK_DEPTH)) begin
            q_tok_mem[fill_reg[SLOT_W-1:0]]  <= push_tok;
            q_slot_mem[fill_reg[SLOT_W-1:0]] <= push_slot;
        end
        if (state_reg == S_RD) begin
            rd_tok_reg  <= q_tok_mem[emit_idx_reg[SLOT_W-1:0]];
            rd_slot_reg <= q_slot_mem[emit_idx_reg[SLOT_W-1:0]];
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(ACK_DEPTH))
        else $error("ack queue fill beyond depth");

    a_out_only_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == S_OUT))
        else $error("result word shown outside the emit state");

    a_busy_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result word waits");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (fill_reg == '0))
        else $error("ack queue not emptied after frame");
`endif

endmodule

/* bench/rscm_checker.sv */
`timescale 1ns / 1ps
// Checker for the response slot claim manager. It watches the input, result and
// register ports, predicts each result word and compares it. Depends on rscm_pkg.
module rscm_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [rscm_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [rscm_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               m_tuser,
    input  logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [7:0]                         cfg_data,
    output int                                 fails,
    output int                                 pending
);
    import rscm_pkg::*;

    typedef struct packed {
        logic        is_ack;
        logic [31:0] open_map;
        logic [31:0] retx_map;
        logic [5:0]  ack_total;
        logic [31:0] ack_token;
        logic [4:0]  ack_slot;
        logic        last;
    } frame_word_t;

    frame_word_t frame_words_due[$];

    // Shadow copy of the block's slot table, counters, queue and registers.
    logic [7:0]  reclaim_limit;
    logic [5:0]  ack_cap_reg;
    logic        owned     [SLOTS];
    logic [31:0] owner_tok [SLOTS];
    logic        responded [SLOTS];
    logic [7:0]  misses    [SLOTS];
    logic [31:0] q_tok     [ACK_DEPTH];
    logic [4:0]  q_slot    [ACK_DEPTH];
    int          q_fill;

    assign pending = frame_words_due.size();

    // Prediction: update the shadow state for each accepted input word.
    always @(posedge aclk) begin : predict
        logic [7:0]  slot, len, fb, frames;
        logic [31:0] tok, retx, open_map;
        int          found, cap, n;
        frame_word_t w;
        if (!aresetn) begin
            reclaim_limit = RECLAIM_RESET;
            ack_cap_reg   = ACK_LIMIT_RESET;
            for (int i = 0; i < SLOTS; i++) begin
                owned[i] = 1'b0;
                owner_tok[i] = '0;
                responded[i] = 1'b0;
                misses[i] = '0;
            end
            q_fill = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_RECLAIM) reclaim_limit = cfg_data;
                else ack_cap_reg = cfg_data[5:0];
            end
            if (s_tvalid && s_tready) begin
                slot   = s_tdata[7:0];
                len    = s_tdata[15:8];
                fb     = s_tdata[23:16];
                tok    = s_tdata[55:24];
                frames = s_tdata[63:56];
                if (s_tuser == 1'b0) begin
                    // Response: possible claim, then mark the slot as heard.
                    if (slot < SLOTS) begin
                        if (len >= CLAIM_MIN_LEN && fb == CLAIM_ID && tok != 0) begin
                            found = -1;
                            for (int i = 0; i < SLOTS; i++)
                                if (found < 0 && owned[i] && owner_tok[i] == tok)
                                    found = i;
                            if (found >= 0) begin
                                if (found == slot && q_fill < ACK_DEPTH) begin
                                    q_tok[q_fill] = tok;
                                    q_slot[q_fill] = slot[4:0];
                                    q_fill++;
                                end
                            end else if (!owned[slot]) begin
                                owned[slot] = 1'b1;
                                owner_tok[slot] = tok;
                                if (q_fill < ACK_DEPTH) begin
                                    q_tok[q_fill] = tok;
                                    q_slot[q_fill] = slot[4:0];
                                    q_fill++;
                                end
                            end
                        end
                        responded[slot] = 1'b1;
                    end
                end else begin
                    // Request: age the misses, reclaim, then build the frame.
                    retx = '0;
                    open_map = '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (owned[i] && !responded[i]) begin
                            retx[i] = 1'b1;
                            if (misses[i] < MISS_MAX) misses[i]++;
                            if (misses[i] >= reclaim_limit) begin
                                owned[i] = 1'b0;
                                owner_tok[i] = '0;
                                misses[i] = '0;
                            end
                        end else if (responded[i]) begin
                            misses[i] = '0;
                        end
                        responded[i] = 1'b0;
                    end
                    if (frames != 0) begin
                        for (int i = 0; i < SLOTS; i++)
                            if (!owned[i]) open_map[i] = 1'b1;
                        cap = (ack_cap_reg > ACK_CAP) ? ACK_CAP : ack_cap_reg;
                        n = (q_fill < cap) ? q_fill : cap;
                        w = '{1'b0, open_map, retx, 6'(n), 32'd0, 5'd0, n == 0};
                        frame_words_due.push_back(w);
                        for (int i = 0; i < n; i++) begin
                            w = '{1'b1, 32'd0, 32'd0, 6'd0, q_tok[i], q_slot[i], i + 1 == n};
                            frame_words_due.push_back(w);
                        end
                    end
                    q_fill = 0;
                end
            end
        end
    end

    // Comparison of each accepted result word with the oldest prediction.
    initial fails = 0;
    always @(posedge aclk) begin : compare
        frame_word_t e, a;
        if (aresetn && m_tvalid && m_tready) begin
            a = '{m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[69:64],
                  m_tdata[101:70], m_tdata[106:102], m_tlast};
            if (frame_words_due.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, a);
                fails++;
            end else begin
                e = frame_words_due.pop_front();
                if (e.is_ack !== a.is_ack) begin
                    $display("%0t: is_ack expected %0d actual %0d", $time, e.is_ack, a.is_ack);
                    fails++;
                end
                if (e.open_map !== a.open_map) begin
                    $display("%0t: open map expected %h actual %h",
                             $time, e.open_map, a.open_map);
                    fails++;
                end
                if (e.retx_map !== a.retx_map) begin
                    $display("%0t: retransmit map expected %h actual %h",
                             $time, e.retx_map, a.retx_map);
                    fails++;
                end
                if (e.ack_total !== a.ack_total) begin
                    $display("%0t: ack total expected %0d actual %0d",
                             $time, e.ack_total, a.ack_total);
                    fails++;
                end
                if (e.ack_token !== a.ack_token) begin
                    $display("%0t: ack_token expected %h actual %h",
                             $time, e.ack_token, a.ack_token);
                    fails++;
                end
                if (e.ack_slot !== a.ack_slot) begin
                    $display("%0t: ack_slot expected %0d actual %0d",
                             $time, e.ack_slot, a.ack_slot);
                    fails++;
                end
                if (e.last !== a.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, e.last, a.last);
                    fails++;
                end
                if (m_tdata[OUT_DATA_W-1:107] !== '0) begin
                    $display("%0t: padding expected 0 actual %h",
                             $time, m_tdata[OUT_DATA_W-1:107]);
                    fails++;
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Top of the response slot claim manager testbench: clock, reset, stimulus and
// verdict. Depends on rscm_pkg, rscm_checker and the block itself.
module tb_top;
    import rscm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 40;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tuser;
    logic                    m_tlast;
    logic                    cfg_we = 1'b0;
    logic                    cfg_index = REG_RECLAIM;
    logic [7:0]              cfg_data = '0;
    int                      fails;
    int                      pending;
    int                      tx_idle_pct = 0;
    int                      rx_idle_pct = 0;
    logic                    hold_flip = 1'b0;
    logic [31:0]             token_pool [40];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    response_slot_claim_manager_top uut (.*);

    rscm_checker chk (.*);

    // Cycle limit guards against a hung block.
    always @(posedge aclk) begin : watchdog
        int cycles;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Sink side: random stalls, plus a long hold-off whenever it is asked for.
    always @(posedge aclk) begin : sink
        int hold_left;
        logic hold_seen;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_seen = hold_flip;
            hold_left = 0;
        end else begin
            if (hold_flip != hold_seen) begin
                hold_seen = hold_flip;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one word and wait until it is taken, idling beforehand at random.
    task automatic send_word(logic cmd, logic [7:0] slot, logic [7:0] len,
                             logic [7:0] fb, logic [31:0] tok, logic [7:0] frames);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {frames, tok, fb, len, slot};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Let the block drain completely, then leave it idle for a while.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // One random word: mostly claims and responses in range, some requests and noise.
    task automatic random_word();
        int roll;
        logic [7:0] slot;
        roll = $urandom_range(99);
        slot = ($urandom_range(15) == 0) ? 8'($urandom_range(32, 255))
                                         : 8'($urandom_range(31));
        if (roll < 12) begin
            send_word(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
                      ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        end else if (roll < 70) begin
            send_word(1'b0, slot, 8'($urandom_range(5, 255)), CLAIM_ID,
                      token_pool[$urandom_range(39)], 8'($urandom));
        end else if (roll < 85) begin
            send_word(1'b0, slot, 8'($urandom), 8'($urandom), $urandom, 8'($urandom));
        end else begin
            // Near-miss claims: short length, wrong identifier or zero token.
            case ($urandom_range(2))
                0: send_word(1'b0, slot, 8'($urandom_range(4)), CLAIM_ID,
                             token_pool[$urandom_range(39)], 8'($urandom));
                1: send_word(1'b0, slot, 8'($urandom_range(5, 255)), CLAIM_ID ^ 8'h10,
                             token_pool[$urandom_range(39)], 8'($urandom));
                default: send_word(1'b0, slot, 8'($urandom_range(5, 255)), CLAIM_ID,
                                   32'd0, 8'($urandom));
            endcase
        end
    endtask

    initial begin : stimulus
        int reclaim_set [3];
        int limit_set [3];
        for (int i = 0; i < 40; i++) token_pool[i] = $urandom | 32'h1;
        token_pool[0] = 32'hFFFF_FFFF;
        token_pool[1] = 32'h0000_0001;
        reclaim_set = '{1, 255, 20};
        limit_set   = '{0, 63, 32};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words with the register defaults.
        send_word(1'b0, 8'd0,   8'd5,   CLAIM_ID, 32'd1,          8'd0);
        send_word(1'b0, 8'd0,   8'd5,   CLAIM_ID, 32'd1,          8'd0);
        send_word(1'b0, 8'd2,   8'd9,   CLAIM_ID, 32'd1,          8'd0);
        send_word(1'b0, 8'd0,   8'd9,   CLAIM_ID, 32'd7,          8'd0);
        send_word(1'b0, 8'd31,  8'd255, CLAIM_ID, 32'hFFFF_FFFF, 8'hFF);
        send_word(1'b0, 8'd200, 8'd9,   CLAIM_ID, 32'd9,          8'd0);
        send_word(1'b0, 8'd255, 8'd9,   CLAIM_ID, 32'd9,          8'd0);
        send_word(1'b0, 8'd3,   8'd4,   CLAIM_ID, 32'd3,          8'd0);
        send_word(1'b0, 8'd4,   8'd5,   8'hC0,    32'd4,          8'd0);
        send_word(1'b0, 8'd5,   8'd5,   CLAIM_ID, 32'd0,          8'd0);
        send_word(1'b0, 8'd6,   8'd0,   8'd0,     32'd0,          8'd0);
        send_word(1'b1, 8'd0,   8'd0,   8'd0,     32'd0,          8'd1);
        send_word(1'b1, 8'hFF,  8'hFF,  8'hFF,    32'hFFFF_FFFF, 8'hFF);
        send_word(1'b0, 8'd0,   8'd5,   CLAIM_ID, 32'd1,          8'd0);
        send_word(1'b1, 8'd0,   8'd0,   8'd0,     32'd0,          8'd0);
        send_word(1'b1, 8'd0,   8'd0,   8'd0,     32'd0,          8'd2);

        // Three idling regimes, each run under a different register setting.
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 25 : (p == 1) ? 50 : 0;
            rx_idle_pct = (p == 0) ? 50 : (p == 1) ? 25 : 0;
            write_reg(REG_RECLAIM, 8'(reclaim_set[p]));
            write_reg(REG_ACK_LIMIT, 8'(limit_set[p]));
            for (int k = 0; k < 125; k++) begin
                if (k == 60) begin
                    // Wait for every frame word before carrying on.
                    drain();
                end
                if (p == 2 && k == 20) begin
                    // Fill the queue with repeated claims, then stall the sink
                    // while requests keep coming so the block backs up.
                    for (int j = 0; j < 36; j++)
                        send_word(1'b0, 8'd9, 8'd5, CLAIM_ID, 32'h5A5A_0009, 8'd0);
                    hold_flip <= ~hold_flip;
                    for (int j = 0; j < 6; j++) begin
                        send_word(1'b1, 8'd0, 8'd0, 8'd0, 32'd0, 8'd1);
                        send_word(1'b0, 8'd9, 8'd5, CLAIM_ID, 32'h5A5A_0009, 8'd0);
                    end
                end
                random_word();
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        if (fails == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
src/rscm_pkg.sv
src/response_slot_claim_manager_top.sv
bench/rscm_checker.sv
bench/tb_top.sv
